### src/cau_pkg.sv
// Shared types, widths and helper functions of the complex arithmetic unit.
// Used by every module under src; depends on nothing else.
package cau_pkg;

  // Word format: signed fixed point with FRAC_BITS fraction bits.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // Exact products and sums of products.
  localparam int PROD_BITS = 2 * WORD_BITS;
  // One quotient bit is produced by each divider cell.
  localparam int QUOT_BITS = WORD_BITS;

  // Operation codes.
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [WORD_BITS-1:0] left_real;
    logic signed [WORD_BITS-1:0] left_imag;
    logic signed [WORD_BITS-1:0] right_real;
    logic signed [WORD_BITS-1:0] right_imag;
  } operand_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] result_real;
    logic signed [WORD_BITS-1:0] result_imag;
    logic                        overflow;
    logic                        divide_by_zero;
  } result_t;

  // One part (real or imaginary) as it travels down the divider chain.
  typedef struct packed {
    logic                 neg;    // sign of the exact value
    logic                 big;    // quotient known to exceed the word
    logic [PROD_BITS-1:0] rem;    // partial remainder, or final magnitude
    logic [QUOT_BITS-1:0] nbits;  // numerator bits still to shift in
    logic [QUOT_BITS-1:0] quot;   // quotient bits produced so far
  } part_t;

  typedef struct packed {
    logic                 div;    // part magnitudes are being divided
    logic                 dbz;    // divide with a zero divisor
    logic [PROD_BITS-1:0] den;    // c*c + d*d
    part_t                re;
    part_t                im;
  } cell_t;

  // Magnitude of an exact signed value that is known to fit PROD_BITS bits.
  function automatic logic [PROD_BITS-1:0] abs_mag(input logic signed [PROD_BITS:0] x);
    logic [PROD_BITS:0] t;
    t = x[PROD_BITS] ? -x : x;
    return t[PROD_BITS-1:0];
  endfunction

endpackage

### src/cau_front.sv
// Front end of the complex arithmetic unit: input register, product stage and
// the stage that forms signed magnitudes and the divisor. Depends on cau_pkg.
module cau_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        adv,
  input  logic              in_valid,
  input  cau_pkg::operand_t in_data,
  output logic [2:0]        valid,
  output cau_pkg::cell_t    out_data
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int PW = cau_pkg::PROD_BITS;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[0]) valid[0] <= in_valid;
      if (adv[1]) valid[1] <= valid[0];
      if (adv[2]) valid[2] <= valid[1];
    end
  end

  // Stage A: operand register.
  cau_pkg::operand_t op;
  always_ff @(posedge clk) begin
    if (adv[0]) op <= in_data;
  end

  // Stage B: the six exact products, plus the sums for add and subtract.
  logic [1:0]           kind_b;
  logic                 dbz_b;
  logic signed [PW-1:0] ac, bd, ad, bc, cc, dd;
  logic signed [W:0]    sum_re, sum_im;
  logic signed [W:0]    ext_a, ext_b, ext_c, ext_d;

  assign ext_a = {op.left_real[W-1], op.left_real};
  assign ext_b = {op.left_imag[W-1], op.left_imag};
  assign ext_c = {op.right_real[W-1], op.right_real};
  assign ext_d = {op.right_imag[W-1], op.right_imag};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      kind_b <= op.kind;
      dbz_b  <= (op.right_real == '0) && (op.right_imag == '0);
      ac     <= PW'(op.left_real) * PW'(op.right_real);
      bd     <= PW'(op.left_imag) * PW'(op.right_imag);
      ad     <= PW'(op.left_real) * PW'(op.right_imag);
      bc     <= PW'(op.left_imag) * PW'(op.right_real);
      cc     <= PW'(op.right_real) * PW'(op.right_real);
      dd     <= PW'(op.right_imag) * PW'(op.right_imag);
      sum_re <= (op.kind == cau_pkg::KIND_ADD) ? ext_a + ext_c : ext_a - ext_c;
      sum_im <= (op.kind == cau_pkg::KIND_ADD) ? ext_b + ext_d : ext_b - ext_d;
    end
  end

  // Stage C: exact real and imaginary values, split into sign and magnitude.
  logic signed [PW:0] xr, xi;
  logic [PW-1:0]      mag_re, mag_im, den;
  cau_pkg::cell_t     cell_next;

  always_comb begin
    case (kind_b)
      cau_pkg::KIND_MUL: begin
        xr = (PW+1)'(ac) - (PW+1)'(bd);
        xi = (PW+1)'(ad) + (PW+1)'(bc);
      end
      cau_pkg::KIND_DIV: begin
        xr = (PW+1)'(ac) + (PW+1)'(bd);
        xi = (PW+1)'(bc) - (PW+1)'(ad);
      end
      default: begin
        xr = (PW+1)'(sum_re);
        xi = (PW+1)'(sum_im);
      end
    endcase
    mag_re = cau_pkg::abs_mag(xr);
    mag_im = cau_pkg::abs_mag(xi);
    den    = cc[PW-1:0] + dd[PW-1:0];

    cell_next.div   = 1'b0;
    cell_next.dbz   = 1'b0;
    cell_next.den   = den;
    cell_next.re    = '0;
    cell_next.im    = '0;
    cell_next.re.neg = xr[PW];
    cell_next.im.neg = xi[PW];
    case (kind_b)
      cau_pkg::KIND_MUL: begin
        // Truncation toward zero of the magnitude.
        cell_next.re.rem = mag_re >> F;
        cell_next.im.rem = mag_im >> F;
      end
      cau_pkg::KIND_DIV: begin
        if (dbz_b) begin
          cell_next.dbz    = 1'b1;
          cell_next.re.neg = 1'b0;
          cell_next.im.neg = 1'b0;
        end else begin
          // Long division of mag * 2^F: the upper part seeds the remainder.
          cell_next.div      = 1'b1;
          cell_next.re.rem   = mag_re >> (W - F);
          cell_next.im.rem   = mag_im >> (W - F);
          cell_next.re.nbits = {mag_re[W-F-1:0], {F{1'b0}}};
          cell_next.im.nbits = {mag_im[W-F-1:0], {F{1'b0}}};
          cell_next.re.big   = (mag_re >> (W - F)) >= den;
          cell_next.im.big   = (mag_im >> (W - F)) >= den;
        end
      end
      default: begin
        cell_next.re.rem = mag_re;
        cell_next.im.rem = mag_im;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) out_data <= cell_next;
  end

endmodule

### src/cau_div_cell.sv
// One cell of the divider chain: produces one quotient bit for both parts.
// Depends on cau_pkg.
module cau_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  cau_pkg::cell_t in_data,
  output logic           valid,
  output cau_pkg::cell_t out_data
);

  localparam int PW = cau_pkg::PROD_BITS;
  localparam int QB = cau_pkg::QUOT_BITS;

  cau_pkg::cell_t cell_next;

  // Restoring step on one part: shift in a numerator bit, try the divisor.
  function automatic cau_pkg::part_t step(input cau_pkg::part_t p,
                                          input logic [PW-1:0] den);
    cau_pkg::part_t o;
    logic [PW:0]    trial;
    logic           fits;
    o     = p;
    trial = {p.rem, p.nbits[QB-1]};
    fits  = trial >= {1'b0, den};
    if (fits) trial = trial - {1'b0, den};
    o.rem   = trial[PW-1:0];
    o.nbits = {p.nbits[QB-2:0], 1'b0};
    o.quot  = {p.quot[QB-2:0], fits};
    return o;
  endfunction

  always_comb begin
    cell_next = in_data;
    if (in_data.div) begin
      cell_next.re = step(in_data.re, in_data.den);
      cell_next.im = step(in_data.im, in_data.den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= cell_next;
  end

endmodule

### src/cau_back.sv
// Back end of the complex arithmetic unit: saturation and the result register.
// Depends on cau_pkg.
module cau_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  cau_pkg::cell_t   in_data,
  output logic             valid,
  output cau_pkg::result_t out_data
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int PW = cau_pkg::PROD_BITS;
  localparam int QB = cau_pkg::QUOT_BITS;
  localparam logic [PW-1:0] MAX_POS = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] MAX_NEG = {{(PW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  // Final magnitude of a part: quotient, saturating marker, or passed value.
  function automatic logic [PW-1:0] final_mag(input cau_pkg::part_t p, input logic div);
    if (!div) return p.rem;
    if (p.big) return '1;
    return {{(PW-QB){1'b0}}, p.quot};
  endfunction

  logic [PW-1:0]    mag_re, mag_im;
  logic             ovf_re, ovf_im;
  logic [W-1:0]     val_re, val_im;
  cau_pkg::result_t res_next;

  always_comb begin
    mag_re = final_mag(in_data.re, in_data.div);
    mag_im = final_mag(in_data.im, in_data.div);

    // Saturate each part to the word range.
    if (!in_data.re.neg) begin
      ovf_re = mag_re > MAX_POS;
      val_re = ovf_re ? MAX_POS[W-1:0] : mag_re[W-1:0];
    end else begin
      ovf_re = mag_re > MAX_NEG;
      val_re = ovf_re ? MAX_NEG[W-1:0] : -mag_re[W-1:0];
    end
    if (!in_data.im.neg) begin
      ovf_im = mag_im > MAX_POS;
      val_im = ovf_im ? MAX_POS[W-1:0] : mag_im[W-1:0];
    end else begin
      ovf_im = mag_im > MAX_NEG;
      val_im = ovf_im ? MAX_NEG[W-1:0] : -mag_im[W-1:0];
    end

    res_next.result_real    = val_re;
    res_next.result_imag    = val_im;
    res_next.overflow       = ovf_re | ovf_im;
    res_next.divide_by_zero = in_data.dbz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data <= res_next;
  end

endmodule

### src/complex_arith_unit.sv
// Complex arithmetic unit on signed Q16.16 operands: add, subtract, multiply
// and divide with saturation. Top level; depends on cau_pkg, cau_front,
// cau_div_cell and cau_back.
//
// Usage:
//   The operand channel (operand_valid, operand_stall, operand) carries one
//   operation and two complex operands per transfer; the result channel
//   (result_valid, result_stall, result) carries one result per operand.
//   Results leave in the order their operands arrived.
// Pipeline and throughput:
//   Every operation goes from its transfer through the input register, then
//   a product stage, a magnitude stage, a chain of 32 divider cells (one
//   quotient bit per cell) and the result register. All operations run
//   through the same chain, so one transfer per cycle is sustained while the
//   result is not stalled.
// Stalling:
//   Each stage moves on whenever it is empty or the stage after it moves, so
//   a stalled result only holds the stages that are full behind it; new
//   operands are still taken until every stage holds an item. The result
//   register keeps its payload while stalled.
// Reset:
//   rst clears every valid bit; items in flight are dropped.
module complex_arith_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              operand_valid,
  output logic              operand_stall,
  input  cau_pkg::operand_t operand,
  output logic              result_valid,
  input  logic              result_stall,
  output cau_pkg::result_t  result
);

  localparam int QB = cau_pkg::QUOT_BITS;
  localparam int NS = 3 + QB + 1;

  logic [NS-1:0]  valid;
  logic [NS-1:0]  adv;
  cau_pkg::cell_t chain [QB+1];

  // Each stage advances when it is empty or its successor advances.
  always_comb begin
    adv[NS-1] = !valid[NS-1] || !result_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  assign operand_stall = !adv[0];

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv[2:0]),
    .in_valid (operand_valid),
    .in_data  (operand),
    .valid    (valid[2:0]),
    .out_data (chain[0])
  );

  // Divider chain: one quotient bit per cell.
  for (genvar g = 0; g < QB; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv[3+g]),
      .in_valid (valid[2+g]),
      .in_data  (chain[g]),
      .valid    (valid[3+g]),
      .out_data (chain[g+1])
    );
  end

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv[NS-1]),
    .in_valid (valid[NS-2]),
    .in_data  (chain[QB]),
    .valid    (valid[NS-1]),
    .out_data (result)
  );

  assign result_valid = valid[NS-1];

endmodule

### src/cau_checker.sv
// Port-level checks on the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arith_unit.
module cau_checker (
  input logic              clk,
  input logic              rst,
  input logic              operand_valid,
  input logic              operand_stall,
  input cau_pkg::operand_t operand,
  input logic              result_valid,
  input logic              result_stall,
  input cau_pkg::result_t  result
);

  // A stalled result keeps its valid and its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result transfer changed");

  // The operand side only stalls when the pipeline is full up to the output.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    operand_stall |-> result_valid && result_stall)
    else $error("operand stalled while pipeline had room");

  // A zero divisor gives a zero result without overflow.
  a_dbz: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.divide_by_zero |->
      result.result_real == '0 && result.result_imag == '0 && !result.overflow)
    else $error("divide by zero result not cleared");

  // No result appears straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (
  .clk           (clk),
  .rst           (rst),
  .operand_valid (operand_valid),
  .operand_stall (operand_stall),
  .operand       (operand),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result        (result)
);
